// File: rtl/core/ms3w_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ms3w_pkg;

  localparam int PIX_W     = 32;
  localparam int SUM_W     = 36;
  localparam int COLSUM_W  = 34;
  localparam int POS_W     = 10;
  localparam int DIM_W     = 11;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 4;
  localparam int WIN       = 3;
  localparam int CELLS     = WIN * WIN;
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 1024;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(3);
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);
  localparam logic signed [SUM_W-1:0] MOST_NEG_SUM = {1'b1, {(SUM_W-1){1'b0}}};

  // what the result sequencer takes over at a frame end or a too-small item
  typedef struct packed {
    logic                          small_frame;
    logic signed [SUM_W-1:0]       sum;
    logic [POS_W-1:0]              top;
    logic [POS_W-1:0]              left;
    logic [CELLS-1:0][PIX_W-1:0]   cells;
  } emit_load_t;

endpackage
`default_nettype wire

// File: rtl/core/ms3w_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface ms3w_pix_if;
  logic                                valid;
  logic                                ready;
  logic signed [ms3w_pkg::PIX_W-1:0]   pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface ms3w_res_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic signed [ms3w_pkg::SUM_W-1:0]   window_sum;
  logic [ms3w_pkg::POS_W-1:0]          top_row;
  logic [ms3w_pkg::POS_W-1:0]          left_col;
  logic [ms3w_pkg::IDX_W-1:0]          element_index;
  logic signed [ms3w_pkg::PIX_W-1:0]   element;
  logic                                last_of_run;

  modport source (output valid, output status, output window_sum, output top_row,
                  output left_col, output element_index, output element,
                  output last_of_run, input ready);
  modport sink (input valid, input status, input window_sum, input top_row,
                input left_col, input element_index, input element,
                input last_of_run, output ready);
endinterface

interface ms3w_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ms3w_pkg::CFG_IDX_W-1:0]      index;
  logic [ms3w_pkg::DIM_W-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ms3w_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module ms3w_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ms3w_pkg::emit_load_t load_data,
  output logic                 free,
  ms3w_res_if.source           results
);
  import ms3w_pkg::*;

  logic             active;
  logic [IDX_W-1:0] idx;
  emit_load_t       held;
  logic             out_fire;
  logic             final_now;

  assign out_fire  = results.valid && results.ready;
  assign final_now = held.small_frame || (idx == LAST_CELL);
  // free now, or the closing transaction goes out this cycle
  assign free      = !active || (results.ready && final_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (out_fire) begin
      if (final_now) begin
        active <= 1'b0;
      end
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

  assign results.valid         = active;
  assign results.status        = held.small_frame;
  assign results.window_sum    = held.small_frame ? '0 : held.sum;
  assign results.top_row       = held.small_frame ? '0 : held.top;
  assign results.left_col      = held.small_frame ? '0 : held.left;
  assign results.element_index = held.small_frame ? '0 : idx;
  assign results.element       = held.small_frame ? '0 : held.cells[idx];
  assign results.last_of_run   = final_now;

endmodule
`default_nettype wire

// File: rtl/core/max_sum_3x3_window_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Finds the 3x3 window with the largest sum in a matrix streamed in raster order, one
// signed 32-bit element per transaction, and after the last element sends nine result
// transactions: best sum, top-left position and one window element each, row-major,
// last_of_run on the ninth; the first window in raster order wins a tie. Dimensions come
// from row_count and col_count (values above 1024 act as 1024); writing either one
// restarts the frame. If either dimension is below 3, every element yields one status
// transaction instead and is otherwise ignored. Elements are taken one per clock
// through a three-stage pipeline (line store read, column sums and window shift, window
// sum and compare). Intake stops only while a frame end or too-small item waits for the
// result sequencer, which is busy until the last of its previous results is taken.
module max_sum_3x3_window_unit (
  input  logic      clk,
  input  logic      rst,
  ms3w_cfg_if.sink  cfg,
  ms3w_pix_if.sink  pixels,
  ms3w_res_if.source results
);
  import ms3w_pkg::*;

  // configuration
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] col_count;
  logic [DIM_W-1:0] rows_eff;
  logic [DIM_W-1:0] cols_eff;
  logic             too_small;
  logic             cfg_restart;

  // raster position of the next element
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos_next;
  logic [POS_W-1:0] col_pos_next;
  logic             at_col_end;
  logic             at_row_end;

  // pipeline control
  logic pix_fire;
  logic adv;
  logic s1_go;
  logic emit_free;
  logic emit_load;

  // line stores, read registered at intake
  logic [PIX_W-1:0]        upper_mem [MAX_COLS];
  logic [PIX_W-1:0]        middle_mem [MAX_COLS];
  logic signed [PIX_W-1:0] rd_up;
  logic signed [PIX_W-1:0] rd_mid;

  // stage 1: element and its position
  logic                    v1;
  logic                    small1;
  logic                    full1;
  logic                    last1;
  logic signed [PIX_W-1:0] x1;
  logic [POS_W-1:0]        c1;
  logic [POS_W-1:0]        top1;
  logic [POS_W-1:0]        left1;
  logic signed [COLSUM_W-1:0] colsum_new;

  // stage 2: window, column sums and the item's flags
  logic                        v2;
  logic                        small2;
  logic                        full2;
  logic                        last2;
  logic [POS_W-1:0]            top2;
  logic [POS_W-1:0]            left2;
  logic [CELLS-1:0][PIX_W-1:0] win;
  logic signed [COLSUM_W-1:0]  colsum [WIN];
  logic signed [SUM_W-1:0]     win_sum;
  logic                        take;
  logic                        need2;

  // best window so far
  logic signed [SUM_W-1:0]     best_total;
  logic [POS_W-1:0]            best_top;
  logic [POS_W-1:0]            best_left;
  logic [CELLS-1:0][PIX_W-1:0] best_cells;
  emit_load_t                  load_data;

  // configuration port
  assign cfg.ready   = 1'b1;
  assign cfg_restart = cfg.valid && (cfg.index == REG_ROW_COUNT || cfg.index == REG_COL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RESET;
      col_count <= DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ROW_COUNT: row_count <= cfg.data;
        REG_COL_COUNT: col_count <= cfg.data;
        default: ;
      endcase
    end
  end

  assign rows_eff  = (row_count > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : row_count;
  assign cols_eff  = (col_count > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : col_count;
  assign too_small = (rows_eff < DIM_W'(WIN)) || (cols_eff < DIM_W'(WIN));

  // whole pipeline moves together; holds only when a result load cannot go in
  assign need2     = small2 || last2;
  assign adv       = !(v2 && need2 && !emit_free);
  assign pixels.ready = adv;
  assign pix_fire  = pixels.valid && adv;
  assign s1_go     = adv && v1 && !small1;

  // raster counters
  assign at_col_end = {1'b0, col_pos} == (cols_eff - DIM_W'(1));
  assign at_row_end = {1'b0, row_pos} == (rows_eff - DIM_W'(1));

  always_comb begin
    col_pos_next = col_pos + POS_W'(1);
    row_pos_next = row_pos;
    if (at_col_end) begin
      col_pos_next = '0;
      row_pos_next = at_row_end ? '0 : row_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (pix_fire && !too_small) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // line stores: read at intake, shifted down one row as stage 1 leaves
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      rd_up  <= upper_mem[col_pos];
      rd_mid <= middle_mem[col_pos];
    end
    if (s1_go) begin
      upper_mem[c1]  <= rd_mid;
      middle_mem[c1] <= x1;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      small1 <= too_small;
      full1  <= (row_pos >= POS_W'(WIN - 1)) && (col_pos >= POS_W'(WIN - 1));
      last1  <= at_col_end && at_row_end;
      x1     <= pixels.pixel_value;
      c1     <= col_pos;
      top1   <= row_pos - POS_W'(WIN - 1);
      left1  <= col_pos - POS_W'(WIN - 1);
    end
  end

  // new right-hand column of the window
  assign colsum_new = COLSUM_W'(rd_up) + COLSUM_W'(rd_mid) + COLSUM_W'(x1);

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      small2 <= small1;
      full2  <= full1;
      last2  <= last1;
      top2   <= top1;
      left2  <= left1;
    end
  end

  // window shifts left by one column, new column at the right
  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int k = 0; k < WIN; k++) begin
        win[k*WIN]     <= win[k*WIN + 1];
        win[k*WIN + 1] <= win[k*WIN + 2];
      end
      win[WIN - 1]       <= rd_up;
      win[2*WIN - 1]     <= rd_mid;
      win[CELLS - 1]     <= x1;
      colsum[0]          <= colsum[1];
      colsum[1]          <= colsum[2];
      colsum[2]          <= colsum_new;
    end
  end

  assign win_sum = SUM_W'(colsum[0]) + SUM_W'(colsum[1]) + SUM_W'(colsum[2]);
  // strict compare keeps the earlier window on a tie
  assign take    = v2 && !small2 && full2 && (win_sum > best_total);

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      best_total <= MOST_NEG_SUM;
      best_top   <= '0;
      best_left  <= '0;
    end else if (adv && v2 && !small2 && last2) begin
      // frame closes: clear tracking for the next frame
      best_total <= MOST_NEG_SUM;
      best_top   <= '0;
      best_left  <= '0;
    end else if (adv && take) begin
      best_total <= win_sum;
      best_top   <= top2;
      best_left  <= left2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      best_cells <= win;
    end
  end

  // hand over the best window including the frame's last compare
  always_comb begin
    load_data.small_frame = small2;
    load_data.sum         = take ? win_sum : best_total;
    load_data.top         = take ? top2 : best_top;
    load_data.left        = take ? left2 : best_left;
    load_data.cells       = take ? win : best_cells;
  end

  assign emit_load = adv && v2 && need2;

  ms3w_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .load_data (load_data),
    .free      (emit_free),
    .results   (results)
  );

  // a frame of valid size always has a window, so the empty marker never goes out
  a_no_empty_best: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.status) |-> (results.window_sum != MOST_NEG_SUM))
    else $error("best sum sent without any window compared");

  // a valid result sequence closes on its ninth element
  a_last_on_ninth: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.status && results.last_of_run) |->
      (results.element_index == LAST_CELL))
    else $error("last_of_run on a result other than the ninth");

  // tracking is clear once a frame has been handed over
  a_restart_after_frame: assert property (@(posedge clk) disable iff (rst)
    (adv && v2 && last2 && !small2) |=> (best_total == MOST_NEG_SUM))
    else $error("best tracking not cleared after frame end");

  // the pipeline only holds while a result load waits on a busy sequencer
  a_hold_cause: assert property (@(posedge clk) disable iff (rst)
    (!adv) |-> (v2 && need2 && results.valid))
    else $error("pipeline held without a pending result load");

endmodule
`default_nettype wire
